[rtl/rpdtp_pkg.sv]
// Shared types and constants for the rotate/project/depth-test point plotter.
package rpdtp_pkg;

    // Screen grid and frame store
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_DEPTH   = 8192;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int SX_W          = $clog2(SCREEN_WIDTH);
    localparam int SY_W          = $clog2(SCREEN_HEIGHT);
    localparam int PIX_W         = SX_W + SY_W + 1;

    // Datapath widths
    localparam int OP_W    = 25;
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = 64;
    localparam int ZQ_W    = 26;
    localparam int INV_W   = 24;
    localparam int HI_SH   = 17;
    localparam int FRAC_SH = 38;
    localparam int Q_W     = ACC_W - FRAC_SH;

    // Stream payload widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // Action codes
    localparam logic [1:0] ACT_PLOT  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_X_COEFFS = 3'd0;
    localparam logic [2:0] REG_Y_COEFFS = 3'd1;
    localparam logic [2:0] REG_Z_COEFFS = 3'd2;
    localparam logic [2:0] REG_CAM_DIST = 3'd3;
    localparam logic [2:0] REG_PROJ_SC  = 3'd4;
    localparam logic [2:0] REG_ASPECT_X = 3'd5;
    localparam logic [2:0] REG_BG_CHAR  = 3'd6;

    // Half-screen offsets in Q.38
    localparam logic signed [ACC_W-1:0] OFFSET_X =
        ACC_W'(SCREEN_WIDTH / 2) <<< FRAC_SH;
    localparam logic signed [ACC_W-1:0] OFFSET_Y =
        ACC_W'(SCREEN_HEIGHT / 2) <<< FRAC_SH;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic                    acc_en;
        logic                    acc_load;
        logic                    acc_hi;
        logic signed [ACC_W-1:0] acc_init;
    } t_mac_ctl;

endpackage

[rtl/rotate_project_depth_test_plot.sv]
// Plot sequencer: rotation, reciprocal, projection and depth test over shared units.
// Plot: 11 rotation steps, the divider (which saturates at once when the quotient would
//   overflow), 11 projection steps and one depth-test read per input beat.
// Read adds a frame-buffer read state before output; one item is in work at a time.
// A finished result sits in the output register while the next beat is taken.
// Reset is synchronous: config and control registers take their defaults; the frame buffer is not cleared.
module rotate_project_depth_test_plot import rpdtp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // point_x[7:0], point_y[15:8], point_z[23:16], glyph[39:24], pixel_index[52:40]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // glyph_out[15:0], depth_out[39:16]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // drawn[0], off_screen[1]
    output logic [1:0]             m_axis_tuser
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MEM  = 7'b0000010,
        ST_ROT  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_PROJ = 7'b0010000,
        ST_TEST = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_st, n_st;

    // config registers
    logic [47:0] r_xc, r_yc, r_zc;
    logic [9:0]  r_cd;
    logic [7:0]  r_ps;
    logic [2:0]  r_ax;
    logic [15:0] r_bg;

    // item and working registers
    logic [3:0]              r_step;
    logic signed [7:0]       r_px, r_py, r_pz;
    logic [15:0]             r_glyph;
    logic signed [OP_W-1:0]  r_rx, r_ry;
    logic [INV_W-1:0]        r_inv;
    logic [10:0]             r_f;
    logic [34:0]             r_gx;
    logic [31:0]             r_gy;
    logic                    r_xneg, r_yneg;
    logic [Q_W-1:0]          r_xq, r_yq;
    logic [ADDR_W-1:0]       r_addr;

    // result and output registers
    logic [15:0]       r_res_glyph, r_m_glyph;
    logic [INV_W-1:0]  r_res_depth, r_m_depth;
    logic              r_res_drawn, r_m_drawn;
    logic              r_res_off, r_m_off;
    logic              r_m_valid;

    // unit connections
    t_mac_ctl                 mac_ctl;
    logic signed [OP_W-1:0]   mac_a, mac_b;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     div_start, div_done;
    logic [INV_W-1:0]         div_quot;
    logic                     fb_en, fb_we;
    logic [ADDR_W-1:0]        fb_addr;
    logic [15:0]              fb_wglyph, fb_rglyph;
    logic [INV_W-1:0]         fb_wdepth, fb_rdepth;

    logic              in_fire, cfg_wr;
    logic [1:0]        in_act;
    logic              zq_pos;
    logic [ACC_W-1:0]  acc_mag;
    logic              x_on, y_on;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
    logic [PIX_W-1:0]  pix_full;
    logic              nearer;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign in_act        = s_axis_tuser;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xc <= 48'd16384;
            r_yc <= 48'd16384 << 16;
            r_zc <= 48'd16384 << 32;
            r_cd <= 10'd100;
            r_ps <= 8'd40;
            r_ax <= 3'd2;
            r_bg <= 16'd32;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_X_COEFFS: r_xc <= pwdata[47:0];
                REG_Y_COEFFS: r_yc <= pwdata[47:0];
                REG_Z_COEFFS: r_zc <= pwdata[47:0];
                REG_CAM_DIST: r_cd <= pwdata[9:0];
                REG_PROJ_SC:  r_ps <= pwdata[7:0];
                REG_ASPECT_X: r_ax <= pwdata[2:0];
                REG_BG_CHAR:  r_bg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // config readback
    always_comb begin
        unique case (paddr[5:3])
            REG_X_COEFFS: prdata = {16'd0, r_xc};
            REG_Y_COEFFS: prdata = {16'd0, r_yc};
            REG_Z_COEFFS: prdata = {16'd0, r_zc};
            REG_CAM_DIST: prdata = {54'd0, r_cd};
            REG_PROJ_SC:  prdata = {56'd0, r_ps};
            REG_ASPECT_X: prdata = {61'd0, r_ax};
            REG_BG_CHAR:  prdata = {48'd0, r_bg};
            default:      prdata = '0;
        endcase
    end

    // screen-coordinate decode of the Q.38 sums
    assign acc_mag  = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    assign zq_pos   = !mac_acc[ACC_W-1] && (mac_acc != '0);
    assign x_on     = r_xneg ? (r_xq == '0) : (r_xq < Q_W'(SCREEN_WIDTH));
    assign y_on     = r_yneg ? (r_yq == '0) : (r_yq < Q_W'(SCREEN_HEIGHT));
    assign sx       = r_xneg ? '0 : r_xq[SX_W-1:0];
    assign sy       = r_yneg ? '0 : r_yq[SY_W-1:0];
    assign pix_full = PIX_W'(sy) * PIX_W'(SCREEN_WIDTH) + PIX_W'(sx);
    assign nearer   = r_inv > fb_rdepth;

    // shared multiplier schedule: issue in step k, accumulate in step k+1
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        if (r_st == ST_ROT) begin
            unique case (r_step)
                4'd0: begin mac_a = OP_W'(signed'(r_xc[15:0]));  mac_b = OP_W'(r_px); end
                4'd1: begin mac_a = OP_W'(signed'(r_xc[31:16])); mac_b = OP_W'(r_py); end
                4'd2: begin mac_a = OP_W'(signed'(r_xc[47:32])); mac_b = OP_W'(r_pz); end
                4'd3: begin mac_a = OP_W'(signed'(r_yc[15:0]));  mac_b = OP_W'(r_px); end
                4'd4: begin mac_a = OP_W'(signed'(r_yc[31:16])); mac_b = OP_W'(r_py); end
                4'd5: begin mac_a = OP_W'(signed'(r_yc[47:32])); mac_b = OP_W'(r_pz); end
                4'd6: begin mac_a = OP_W'(signed'(r_zc[15:0]));  mac_b = OP_W'(r_px); end
                4'd7: begin mac_a = OP_W'(signed'(r_zc[31:16])); mac_b = OP_W'(r_py); end
                4'd8: begin mac_a = OP_W'(signed'(r_zc[47:32])); mac_b = OP_W'(r_pz); end
                default: ;
            endcase
            mac_ctl.acc_en   = (r_step >= 4'd1) && (r_step <= 4'd9);
            mac_ctl.acc_load = (r_step == 4'd1) || (r_step == 4'd4) || (r_step == 4'd7);
            if (r_step == 4'd7) begin
                mac_ctl.acc_init = {40'd0, r_cd, 14'd0};
            end
        end else if (r_st == ST_PROJ) begin
            unique case (r_step)
                4'd0: begin mac_a = {17'd0, r_ps};       mac_b = {22'd0, r_ax}; end
                4'd1: begin mac_a = {1'b0, r_inv};       mac_b = {17'd0, r_ps}; end
                4'd2: begin mac_a = {1'b0, r_inv};       mac_b = {14'd0, r_f};  end
                4'd4: begin mac_a = {8'd0, r_gx[16:0]};  mac_b = r_rx; end
                4'd5: begin mac_a = {7'd0, r_gx[34:17]}; mac_b = r_rx; end
                4'd6: begin mac_a = {8'd0, r_gy[16:0]};  mac_b = r_ry; end
                4'd7: begin mac_a = {10'd0, r_gy[31:17]}; mac_b = r_ry; end
                default: ;
            endcase
            mac_ctl.acc_en   = (r_step >= 4'd5) && (r_step <= 4'd8);
            mac_ctl.acc_load = (r_step == 4'd5) || (r_step == 4'd7);
            mac_ctl.acc_hi   = (r_step == 4'd6) || (r_step == 4'd8);
            mac_ctl.acc_init = (r_step == 4'd5) ? OFFSET_X : OFFSET_Y;
        end
    end

    assign div_start = (r_st == ST_ROT) && (r_step == 4'd10) && zq_pos;

    // frame buffer port
    always_comb begin
        fb_en     = 1'b0;
        fb_we     = 1'b0;
        fb_addr   = r_addr;
        fb_wglyph = r_glyph;
        fb_wdepth = r_inv;
        if (in_fire) begin
            fb_addr   = s_axis_tdata[40 +: ADDR_W];
            fb_wglyph = r_bg;
            fb_wdepth = '0;
            fb_en     = (in_act == ACT_READ) || (in_act == ACT_CLEAR);
            fb_we     = (in_act == ACT_CLEAR);
        end else if ((r_st == ST_PROJ) && (r_step == 4'd10)) begin
            fb_addr = pix_full[ADDR_W-1:0];
            fb_en   = x_on && y_on;
        end else if (r_st == ST_TEST) begin
            fb_en = nearer;
            fb_we = nearer;
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (in_fire) begin
                    n_st = (in_act == ACT_PLOT) ? ST_ROT :
                           (in_act == ACT_READ) ? ST_MEM : ST_OUT;
                end
            end
            ST_MEM:  n_st = ST_OUT;
            ST_ROT:  if (r_step == 4'd10) n_st = zq_pos ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done) n_st = ST_PROJ;
            ST_PROJ: if (r_step == 4'd10) n_st = (x_on && y_on) ? ST_TEST : ST_OUT;
            ST_TEST: n_st = ST_OUT;
            ST_OUT:  if (!r_m_valid || m_axis_tready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // control: state, step counter, output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (n_st != r_st) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 4'd1;
            end
            if ((r_st == ST_OUT) && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_px        <= s_axis_tdata[7:0];
            r_py        <= s_axis_tdata[15:8];
            r_pz        <= s_axis_tdata[23:16];
            r_glyph     <= s_axis_tdata[39:24];
            r_res_glyph <= '0;
            r_res_depth <= '0;
            r_res_drawn <= 1'b0;
            r_res_off   <= 1'b0;
        end
        if (r_st == ST_MEM) begin
            r_res_glyph <= fb_rglyph;
            r_res_depth <= fb_rdepth;
        end
        if (r_st == ST_ROT) begin
            if (r_step == 4'd4) r_rx <= mac_acc[OP_W-1:0];
            if (r_step == 4'd7) r_ry <= mac_acc[OP_W-1:0];
            // behind the camera or level with it
            if ((r_step == 4'd10) && !zq_pos) r_res_off <= 1'b1;
        end
        if (div_done) begin
            r_inv       <= div_quot;
            r_res_depth <= div_quot;
        end
        if (r_st == ST_PROJ) begin
            unique case (r_step)
                4'd1: r_f  <= mac_prod[10:0];
                4'd2: r_gy <= mac_prod[31:0];
                4'd3: r_gx <= mac_prod[34:0];
                4'd7: begin
                    r_xneg <= mac_acc[ACC_W-1];
                    r_xq   <= acc_mag[ACC_W-1:FRAC_SH];
                end
                4'd9: begin
                    r_yneg <= mac_acc[ACC_W-1];
                    r_yq   <= acc_mag[ACC_W-1:FRAC_SH];
                end
                4'd10: begin
                    r_addr    <= pix_full[ADDR_W-1:0];
                    r_res_off <= !(x_on && y_on);
                end
                default: ;
            endcase
        end
        if (r_st == ST_TEST) begin
            r_res_drawn <= nearer;
        end
        if ((r_st == ST_OUT) && (!r_m_valid || m_axis_tready)) begin
            r_m_glyph <= r_res_glyph;
            r_m_depth <= r_res_depth;
            r_m_drawn <= r_res_drawn;
            r_m_off   <= r_res_off;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_depth, r_m_glyph};
    assign m_axis_tuser  = {r_m_off, r_m_drawn};

    rpdtp_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    rpdtp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (mac_acc[ZQ_W-1:0]),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    rpdtp_fb u_fb (
        .i_clk    (i_clk),
        .i_en     (fb_en),
        .i_we     (fb_we),
        .i_addr   (fb_addr),
        .i_wglyph (fb_wglyph),
        .i_wdepth (fb_wdepth),
        .o_rglyph (fb_rglyph),
        .o_rdepth (fb_rdepth)
    );

`ifndef SYNTH
    // a drawn pixel is never also reported off screen
    a_drawn_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_drawn && r_m_off))
        else $error("drawn and off_screen both set");

    // the divider only finishes while the sequencer waits for it
    a_div_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_st == ST_DIV))
        else $error("divider done outside divide phase");

    // a drawn point beats a stored depth, so its depth is nonzero
    a_drawn_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_drawn) |-> (r_m_depth != '0))
        else $error("drawn with zero depth");

    // the frame buffer is written in a plot only after the depth read
    a_plot_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fb_we && !in_fire) |-> ($past(r_st) == ST_PROJ))
        else $error("plot write without depth read");
`endif

endmodule

[rtl/rpdtp_mac.sv]
// Shared signed multiplier with a registered product and a 64-bit accumulator.
module rpdtp_mac import rpdtp_pkg::*; (
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [OP_W-1:0]   i_a,
    input  logic signed [OP_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  pext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  base;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // accumulate stage: optional preload, product optionally weighted by 2^17
    always_comb begin
        pext   = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        addend = '0;
        if (i_ctl.acc_en) begin
            addend = i_ctl.acc_hi ? (pext <<< HI_SH) : pext;
        end
        base = i_ctl.acc_load ? i_ctl.acc_init : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en || i_ctl.acc_load) begin
            r_acc <= base + addend;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

[rtl/rpdtp_div.sv]
// Restoring divider for the inverse depth floor(2^38 / zq), saturated to 24 bits.
module rpdtp_div import rpdtp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ZQ_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [INV_W-1:0] o_quot
);

    localparam logic [ZQ_W-1:0] SAT_LIMIT = ZQ_W'(1) << (FRAC_SH - INV_W);

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [ZQ_W:0]    r_rem;
    logic [ZQ_W-1:0]  r_div;
    logic [INV_W-1:0] r_q;
    logic [ZQ_W:0]    shifted;
    logic             fits;

    // one quotient bit per cycle; dividend bits below the top are all zero
    always_comb begin
        shifted = {r_rem[ZQ_W-1:0], 1'b0};
        fits    = shifted >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div <= i_divisor;
                if (i_divisor <= SAT_LIMIT) begin
                    // quotient would need 25 bits or more
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_rem  <= (ZQ_W+1)'(SAT_LIMIT);
                    r_cnt  <= 5'(INV_W - 1);
                end
            end else if (r_busy) begin
                r_rem <= fits ? (shifted - {1'b0, r_div}) : shifted;
                r_q   <= {r_q[INV_W-2:0], fits};
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/rpdtp_fb.sv]
// Frame buffer: glyph and inverse depth per pixel, one port, registered read.
module rpdtp_fb import rpdtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [15:0]       i_wglyph,
    input  logic [INV_W-1:0]  i_wdepth,
    output logic [15:0]       o_rglyph,
    output logic [INV_W-1:0]  o_rdepth
);

    logic [15:0]      mem_glyph [STORE_DEPTH];
    logic [INV_W-1:0] mem_depth [STORE_DEPTH];
    logic [15:0]      r_rglyph;
    logic [INV_W-1:0] r_rdepth;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem_glyph[i_addr] <= i_wglyph;
                mem_depth[i_addr] <= i_wdepth;
            end else begin
                r_rglyph <= mem_glyph[i_addr];
                r_rdepth <= mem_depth[i_addr];
            end
        end
    end

    assign o_rglyph = r_rglyph;
    assign o_rdepth = r_rdepth;

endmodule

[sim/tb_top.sv]
// Testbench for the point plotter: scoreboard-checked plot, read and clear traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpdtp_pkg::*;

    // Mirror of the plotter: registers, frame store and results still to come
    class plot_scoreboard;
        logic [47:0] row_x, row_y, row_z;
        logic [9:0]  cam_dist;
        logic [7:0]  proj_scale;
        logic [2:0]  aspect;
        logic [15:0] bg_char;
        logic [15:0] glyph_mem [STORE_DEPTH];
        logic [23:0] depth_mem [STORE_DEPTH];
        // {glyph_out, depth_out, off_screen, drawn}
        logic [41:0] pending_results [$];
        int errors, n_plot, n_drawn, n_off, n_read, n_clear;

        function new();
            row_x = 48'd16384;
            row_y = 48'd16384 << 16;
            row_z = 48'd16384 << 32;
            cam_dist = 10'd100;
            proj_scale = 8'd40;
            aspect = 3'd2;
            bg_char = 16'd32;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_X_COEFFS: row_x = val[47:0];
                REG_Y_COEFFS: row_y = val[47:0];
                REG_Z_COEFFS: row_z = val[47:0];
                REG_CAM_DIST: cam_dist = val[9:0];
                REG_PROJ_SC:  proj_scale = val[7:0];
                REG_ASPECT_X: aspect = val[2:0];
                REG_BG_CHAR:  bg_char = val[15:0];
                default: ;
            endcase
        endfunction

        function longint rotate_row(logic [47:0] r, longint px, longint py, longint pz);
            longint a, b, c;
            a = longint'($signed(r[15:0]));
            b = longint'($signed(r[31:16]));
            c = longint'($signed(r[47:32]));
            return a * px + b * py + c * pz;
        endfunction

        // Q.38 to integer, rounding toward zero
        function longint q38_to_int(longint v);
            if (v >= 0) return v >>> 38;
            return -((-v) >>> 38);
        endfunction

        // Predict the result of an accepted input beat and update the store
        function void note_input(logic [1:0] act, logic [IN_TDATA_W-1:0] d);
            logic [15:0] g_o;
            logic [23:0] d_o;
            logic drawn, off;
            longint px, py, pz, rx, ry, zq, inv, sx, sy;
            int a;
            g_o = '0; d_o = '0; drawn = 0; off = 0;
            case (act)
                ACT_PLOT: begin
                    n_plot++;
                    px = longint'($signed(d[7:0]));
                    py = longint'($signed(d[15:8]));
                    pz = longint'($signed(d[23:16]));
                    rx = rotate_row(row_x, px, py, pz);
                    ry = rotate_row(row_y, px, py, pz);
                    zq = rotate_row(row_z, px, py, pz) + (longint'(cam_dist) << 14);
                    if (zq <= 0) begin
                        off = 1;
                    end else begin
                        inv = (longint'(1) << 38) / zq;
                        if (inv > 24'hFFFFFF) inv = 24'hFFFFFF;
                        d_o = inv[23:0];
                        sx = q38_to_int(inv * rx * longint'(proj_scale) * longint'(aspect)
                                        + (longint'(SCREEN_WIDTH / 2) << 38));
                        sy = q38_to_int(inv * ry * longint'(proj_scale)
                                        + (longint'(SCREEN_HEIGHT / 2) << 38));
                        if (sx < 0 || sx >= SCREEN_WIDTH || sy < 0 || sy >= SCREEN_HEIGHT) begin
                            off = 1;
                        end else begin
                            a = int'((sx + sy * SCREEN_WIDTH) & (STORE_DEPTH - 1));
                            if (inv > longint'(depth_mem[a])) begin
                                depth_mem[a] = inv[23:0];
                                glyph_mem[a] = d[39:24];
                                drawn = 1;
                            end
                        end
                    end
                    if (drawn) n_drawn++;
                    if (off) n_off++;
                end
                ACT_READ: begin
                    n_read++;
                    g_o = glyph_mem[d[52:40]];
                    d_o = depth_mem[d[52:40]];
                end
                ACT_CLEAR: begin
                    n_clear++;
                    glyph_mem[d[52:40]] = bg_char;
                    depth_mem[d[52:40]] = '0;
                end
                default: ;
            endcase
            pending_results.push_back({g_o, d_o, off, drawn});
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(logic [OUT_TDATA_W-1:0] d, logic [1:0] u);
            logic [41:0] e;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h tuser=%b", d, u);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (d[15:0] !== e[41:26]) begin
                $error("glyph_out: expected %0d, got %0d", e[41:26], d[15:0]);
                errors++;
            end
            if (d[39:16] !== e[25:2]) begin
                $error("depth_out: expected %0d, got %0d", e[25:2], d[39:16]);
                errors++;
            end
            if (u[0] !== e[0]) begin
                $error("drawn: expected %0b, got %0b", e[0], u[0]);
                errors++;
            end
            if (u[1] !== e[1]) begin
                $error("off_screen: expected %0b, got %0b", e[1], u[1]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   psel = 0, penable = 0, pwrite = 0;
    logic [5:0]             paddr = '0;
    logic [63:0]            pwdata = '0;
    logic [63:0]            prdata;
    logic                   pready;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    plot_scoreboard sb = new();
    bit calm_sender = 0;
    bit calm_receiver = 0;
    int cfg_writes = 0;

    rotate_project_depth_test_plot i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Result side: sample at the falling edge, act on the rising edge
    logic                   smp_valid, smp_ready;
    logic [OUT_TDATA_W-1:0] smp_data;
    logic [1:0]             smp_user;
    always @(negedge i_clk) begin
        smp_valid = m_tvalid;
        smp_ready = m_tready;
        smp_data  = m_tdata;
        smp_user  = m_tuser;
    end
    always @(posedge i_clk) begin
        if (i_rst_n && smp_valid === 1'b1 && smp_ready)
            sb.check_result(smp_data, smp_user);
        m_tready <= calm_receiver || ($urandom_range(0, 99) >= 10);
    end

    // One input beat; valid stays high across back-to-back beats unless the sender idles
    task automatic send_beat(logic [1:0] act, logic [IN_TDATA_W-1:0] d);
        bit took;
        while (!calm_sender && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= d;
        do begin
            @(negedge i_clk);
            took = s_tready;
            @(posedge i_clk);
        end while (!took);
        sb.note_input(act, d);
    endtask

    task automatic send_plot(int x, int y, int z, logic [15:0] g);
        send_beat(ACT_PLOT, {16'd0, g, 8'(z), 8'(y), 8'(x)});
    endtask

    task automatic send_pixel(logic [1:0] act, logic [12:0] idx);
        send_beat(act, {3'd0, idx, 16'($urandom), 24'($urandom)});
    endtask

    // Let every expected result come back, then give the block time to settle
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        sb.write_reg(idx, val);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [47:0] rx, logic [47:0] ry, logic [47:0] rz,
                              logic [9:0] cam, logic [7:0] sc, logic [2:0] asp,
                              logic [15:0] bg);
        drain();
        apb_write(REG_X_COEFFS, {16'd0, rx});
        apb_write(REG_Y_COEFFS, {16'd0, ry});
        apb_write(REG_Z_COEFFS, {16'd0, rz});
        apb_write(REG_CAM_DIST, {54'd0, cam});
        apb_write(REG_PROJ_SC,  {56'd0, sc});
        apb_write(REG_ASPECT_X, {61'd0, asp});
        apb_write(REG_BG_CHAR,  {48'd0, bg});
    endtask

    // Modest coefficient, within a rotation's range of -16384 to 16384
    function automatic logic [15:0] coef();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [47:0] coef_row();
        return {coef(), coef(), coef()};
    endfunction

    // Random traffic: mostly plots near the origin, with reads, clears and noise
    task automatic random_traffic(int count);
        int sel, span;
        for (int i = 0; i < count; i++) begin
            calm_sender = (i >= count / 3 && i < count / 3 + 40);
            sel = $urandom_range(0, 99);
            span = ($urandom_range(0, 3) == 0) ? 128 : 40;
            if (sel < 62)
                send_plot($urandom_range(0, 2 * span - 1) - span,
                          $urandom_range(0, 2 * span - 1) - span,
                          $urandom_range(0, 2 * span - 1) - span, 16'($urandom));
            else if (sel < 82)
                send_pixel(ACT_READ, 13'($urandom));
            else if (sel < 95)
                send_pixel(ACT_CLEAR, 13'($urandom));
            else
                send_pixel(2'd3, 13'($urandom));
        end
        calm_sender = 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Frame clear: every store entry gets written before any read or test
        calm_sender = 1;
        for (int p = 0; p < STORE_DEPTH; p++) send_pixel(ACT_CLEAR, 13'(p));
        calm_sender = 0;

        // Directed points at the reset settings
        send_plot(0, 0, 0, 16'h0041);
        send_plot(0, 0, 0, 16'h0042);        // equal depth, no write
        send_pixel(ACT_READ, 13'(32 * SCREEN_WIDTH + 64));
        send_plot(0, -81, 0, 16'hFFFF);      // row just below zero truncates to 0
        send_pixel(ACT_READ, 13'(64));
        send_plot(0, 0, -128, 16'h1234);     // behind the camera
        send_plot(0, 0, -100, 16'h1234);     // depth exactly zero
        send_plot(0, 0, -99, 16'h5678);      // reciprocal saturates
        send_plot(127, 127, 127, 16'h7FFF);
        send_plot(-128, -128, 127, 16'h8000);
        send_plot(-128, 0, 0, 16'h0001);
        send_pixel(2'd3, 13'h1FFF);          // unused action
        send_pixel(ACT_CLEAR, 13'h1FFF);
        send_pixel(ACT_READ, 13'h1FFF);
        send_pixel(ACT_READ, 13'h0000);

        random_traffic(100);

        // Sender holds off until the block has emptied
        drain();
        random_traffic(40);

        set_config(coef_row(), coef_row(), coef_row(), 10'd150, 8'd30, 3'd1, 16'h002E);
        random_traffic(90);

        // Extremes: all-ones rows, farthest camera, largest scale and aspect
        set_config('1, '1, '1, 10'd1023, 8'd255, 3'd7, 16'hFFFF);
        random_traffic(40);

        // Zero camera, zero scale, zero aspect
        set_config(48'd16384, 48'd16384 << 16, 48'd16384 << 32,
                   10'd0, 8'd0, 3'd0, 16'h0000);
        send_plot(0, 0, -1, 16'h0001);
        random_traffic(40);

        // Fully random register contents
        set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   10'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
        random_traffic(50);

        set_config(coef_row(), coef_row(), coef_row(), 10'd60, 8'd20, 3'd4, 16'h0023);
        random_traffic(90);

        calm_receiver = 1;
        random_traffic(20);
        calm_receiver = 0;
        drain();

        $display("covered %0d plots (%0d drawn, %0d dropped), %0d reads, %0d clears",
                 sb.n_plot, sb.n_drawn, sb.n_off, sb.n_read, sb.n_clear);
        $display("over %0d register writes in six settings", cfg_writes);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
